// ----- sv/sli_pkg.sv -----
`timescale 1ns / 1ps

package sli_pkg;

    // list geometry
    localparam int MAX_LEN_DEF = 64;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 7;

    // function codes of an input item
    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_RUN    = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] match_value;
        logic               last;
        logic               empty_res;
        logic [COUNT_W-1:0] match_count;
        logic               overflowed;
    } out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } sli_state_t;

endpackage

// ----- sv/sli_ram.sv -----
`timescale 1ns / 1ps

module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/sorted_list_intersection_core.sv -----
`timescale 1ns / 1ps
// load items (append to list a or b) are taken one per cycle while idle and give no result
// a run item walks both lists in merge steps (at most la + lb steps),
// one step per cycle, set by the single read port of each list memory
// a step that finds a match waits while the output register is still full
// reset (rst_n low, asynchronous) empties both lists and clears the overflow mark

module sorted_list_intersection_core
    import sli_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_item,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    localparam int IDX_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam logic [IDX_W-1:0] FULL = IDX_W'(MAX_LEN);
    localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);

    sli_state_t state_reg, state_next;

    logic [IDX_W-1:0]   length_a_reg, length_a_next;
    logic [IDX_W-1:0]   length_b_reg, length_b_next;
    logic               ovf_reg, ovf_next;
    logic [IDX_W-1:0]   ia_reg, ia_next;
    logic [IDX_W-1:0]   ib_reg, ib_next;
    logic [IDX_W-1:0]   cnt_reg, cnt_next;
    logic               hold_valid_reg, hold_valid_next;
    logic [VALUE_W-1:0] hold_value_reg, hold_value_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic               we_a, we_b;
    logic [ADDR_W-1:0]  ra, rb;
    logic [VALUE_W-1:0] a_data, b_data;

    logic in_fire;
    logic out_free;
    logic walk_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign walk_done = (ia_reg >= length_a_reg) || (ib_reg >= length_b_reg);

    // list stores
    sli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_LEN)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (length_a_reg[ADDR_W-1:0]),
        .wdata (in_item.value),
        .raddr (ra),
        .rdata (a_data)
    );

    sli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_LEN)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (length_b_reg[ADDR_W-1:0]),
        .wdata (in_item.value),
        .raddr (rb),
        .rdata (b_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_item.func == FUNC_RUN)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        length_a_next   = length_a_reg;
        length_b_next   = length_b_reg;
        ovf_next        = ovf_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        we_a            = 1'b0;
        we_b            = 1'b0;
        ra              = ia_reg[ADDR_W-1:0];
        rb              = ib_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                // heads of both lists are read while waiting
                ra = '0;
                rb = '0;
                if (in_fire)
                begin
                    case (in_item.func)
                        FUNC_LOAD_A:
                        begin
                            if (length_a_reg < FULL)
                            begin
                                we_a          = 1'b1;
                                length_a_next = length_a_reg + ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FUNC_LOAD_B:
                        begin
                            if (length_b_reg < FULL)
                            begin
                                we_b          = 1'b1;
                                length_b_next = length_b_reg + ONE;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        FUNC_RUN:
                        begin
                            ia_next         = '0;
                            ib_next         = '0;
                            cnt_next        = '0;
                            hold_valid_next = 1'b0;
                        end
                        default:
                        begin
                            ia_next = ia_reg;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                // one merge step; a match is held back until the next one
                // or the end of the walk decides its last flag
                if (!walk_done)
                begin
                    if (a_data == b_data)
                    begin
                        if (!hold_valid_reg || out_free)
                        begin
                            if (hold_valid_reg)
                            begin
                                out_valid_next          = 1'b1;
                                out_next.match_value    = hold_value_reg;
                                out_next.last           = 1'b0;
                                out_next.empty_res      = 1'b0;
                                out_next.match_count    = COUNT_W'(cnt_reg);
                                out_next.overflowed     = ovf_reg;
                            end
                            hold_valid_next = 1'b1;
                            hold_value_next = a_data;
                            cnt_next        = cnt_reg + ONE;
                            ia_next         = ia_reg + ONE;
                            ib_next         = ib_reg + ONE;
                        end
                    end
                    else if (a_data < b_data)
                    begin
                        ia_next = ia_reg + ONE;
                    end
                    else
                    begin
                        ib_next = ib_reg + ONE;
                    end
                end
                // address of the next step, or a re-read when stalled
                ra = ia_next[ADDR_W-1:0];
                rb = ib_next[ADDR_W-1:0];
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.last        = 1'b1;
                    out_next.overflowed  = ovf_reg;
                    if (hold_valid_reg)
                    begin
                        out_next.match_value = hold_value_reg;
                        out_next.empty_res   = 1'b0;
                        out_next.match_count = COUNT_W'(cnt_reg);
                    end
                    else
                    begin
                        out_next.match_value = '0;
                        out_next.empty_res   = 1'b1;
                        out_next.match_count = '0;
                    end
                    length_a_next   = '0;
                    length_b_next   = '0;
                    ovf_next        = 1'b0;
                    hold_valid_next = 1'b0;
                end
            end
            default:
            begin
                ovf_next = ovf_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            length_a_reg   <= '0;
            length_b_reg   <= '0;
            ovf_reg        <= 1'b0;
            ia_reg         <= '0;
            ib_reg         <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            length_a_reg   <= length_a_next;
            length_b_reg   <= length_b_next;
            ovf_reg        <= ovf_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_value_reg <= hold_value_next;
        out_reg        <= out_next;
    end

    // walk indexes never pass the list lengths
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> ia_reg <= length_a_reg && ib_reg <= length_b_reg)
        else $error("walk index beyond list length");

    // lists never grow past capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        length_a_reg <= FULL && length_b_reg <= FULL)
        else $error("list length beyond capacity");

    // a held match always has a nonzero running count
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> cnt_reg != '0)
        else $error("held match without count");

    // the empty result is the single, last result with zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.empty_res |->
            out_reg.last && out_reg.match_count == '0 && out_reg.match_value == '0)
        else $error("malformed empty result");

    // finishing a run returns to idle with both lists emptied
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && out_free |=>
            state_reg == ST_IDLE && length_a_reg == '0 && length_b_reg == '0 && !ovf_reg)
        else $error("run did not clear lists");

endmodule
